FILE: sv/csfb_pkg.sv
// Package for the color sensor frequency balancer.
// Holds register indexes, widths and the sequencer's microcode table.
// No dependencies.
`default_nettype none

package csfb_pkg;

    localparam int WIN_WIDTH       = 24;
    localparam int SCALE_WIDTH     = 2;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int VALUE_WIDTH     = 8;
    localparam int PC_WIDTH        = 3;
    localparam int DIV_CNT_WIDTH   = 4;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_TICKS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FREQ_SCALE   = 2'd1;

    localparam logic [WIN_WIDTH-1:0]     WINDOW_RESET = 24'd100000;
    localparam logic [SCALE_WIDTH-1:0]   SCALE_RESET  = 2'd1;
    localparam logic [VALUE_WIDTH-1:0]   VALUE_MAX    = 8'hFF;
    localparam logic [DIV_CNT_WIDTH-1:0] DIV_TOP_BIT  = 4'd8;

    localparam logic [1:0] PHASE_RED   = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_BLUE  = 2'd2;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_DIV  = 2'd2;
    localparam logic [1:0] OP_EMIT = 2'd3;

    localparam logic [1:0] COND_NEXT     = 2'd0;
    localparam logic [1:0] COND_NO_DIV   = 2'd1;
    localparam logic [1:0] COND_DIV_BUSY = 2'd2;
    localparam logic [1:0] COND_OUT_BUSY = 2'd3;

    typedef struct packed {
        logic [1:0]          op;
        logic [1:0]          color;
        logic [1:0]          cond;
        logic [PC_WIDTH-1:0] target;
    } ctrl_word_t;

    // When the condition holds the sequencer jumps to target, else it steps on.
    function automatic ctrl_word_t ucode(input logic [PC_WIDTH-1:0] pc);
        ctrl_word_t w;
        case (pc)
            3'd0:    w = '{OP_TICK, PHASE_RED,   COND_NO_DIV,   3'd0};
            3'd1:    w = '{OP_LOAD, PHASE_RED,   COND_NEXT,     3'd0};
            3'd2:    w = '{OP_DIV,  PHASE_RED,   COND_DIV_BUSY, 3'd2};
            3'd3:    w = '{OP_LOAD, PHASE_GREEN, COND_NEXT,     3'd0};
            3'd4:    w = '{OP_DIV,  PHASE_GREEN, COND_DIV_BUSY, 3'd4};
            3'd5:    w = '{OP_LOAD, PHASE_BLUE,  COND_NEXT,     3'd0};
            3'd6:    w = '{OP_DIV,  PHASE_BLUE,  COND_DIV_BUSY, 3'd6};
            3'd7:    w = '{OP_EMIT, PHASE_RED,   COND_OUT_BUSY, 3'd7};
            default: w = '{OP_TICK, PHASE_RED,   COND_NO_DIV,   3'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: sv/color_sensor_frequency_balancer_top.sv
// Top level of the color sensor frequency balancer: tick counting, filter
// sequencing and a microcoded white-balance divider. Depends on csfb_pkg.
`default_nettype none

// Each request is one sample tick of the sensor pin and yields one result that
// shows the filter-select levels for the window now running. A plain tick is
// handled without a stall while the output register is free. The tick that ends a
// measured blue window starts a short microcode program that runs the three
// count*255/reference divisions one after another on a single restoring divider,
// a load and nine compare-subtract steps per color, and then hands the result
// over once the output register is free. No request is taken during that program.
// Configuration is written through the cfg port, which is always ready.
module color_sensor_frequency_balancer_top
    import csfb_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       sensor_level,
    input  wire logic                       recalibrate,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            filter_s2,
    output logic                            filter_s3,
    output logic [SCALE_WIDTH-1:0]          scale_pins,
    output logic                            color_valid,
    output logic [VALUE_WIDTH-1:0]          red_value,
    output logic [VALUE_WIDTH-1:0]          green_value,
    output logic [VALUE_WIDTH-1:0]          blue_value,
    output logic                            calibrating,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [WIN_WIDTH-1:0]       cfg_data
);

    localparam int NUM_WIDTH = COUNT_WIDTH + VALUE_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [WIN_WIDTH-1:0]   window_reg;
    logic [SCALE_WIDTH-1:0] scale_reg;

    logic [COUNT_WIDTH-1:0] edge_reg, edge_next;
    logic [WIN_WIDTH-1:0]   tick_reg, tick_next;
    logic [1:0]             phase_reg, phase_next;
    logic                   prev_reg, prev_next;
    logic                   cal_reg, cal_next;
    logic [COUNT_WIDTH-1:0] round_reg [3];
    logic [COUNT_WIDTH-1:0] white_reg [3];

    logic [PC_WIDTH-1:0]      pc_reg, pc_next;
    logic [NUM_WIDTH-1:0]     rem_reg, rem_next;
    logic [NUM_WIDTH-1:0]     dsh_reg, dsh_next;
    logic [DIV_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0]   quo_reg, quo_next;
    logic                     sat_reg, sat_next;
    logic [VALUE_WIDTH-1:0]   res_reg [3];

    logic                   out_valid_reg;
    logic                   s2_reg, s3_reg, cv_reg, calib_reg;
    logic [SCALE_WIDTH-1:0] scale_out_reg;
    logic [VALUE_WIDTH-1:0] red_reg, green_reg, blue_reg;

    ctrl_word_t             cw;
    logic                   accept;
    logic                   out_busy;
    logic                   need_div;
    logic                   window_end;
    logic                   cond_true;
    logic                   div_ge;
    logic [1:0]             phase_cur;
    logic [WIN_WIDTH-1:0]   win_eff;
    logic [COUNT_WIDTH-1:0] edge_inc;
    logic [NUM_WIDTH-1:0]   numer;
    logic                   load_tick, load_emit;
    logic [1:0]             show_phase;
    logic                   show_cal;

    assign cw        = ucode(pc_reg);
    assign out_busy  = out_valid_reg && out_stall;
    assign in_stall  = (pc_reg != 3'd0) || out_busy;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign phase_cur = (phase_reg == 2'd3) ? PHASE_RED : phase_reg;
    assign win_eff   = (window_reg == '0) ? {{(WIN_WIDTH-1){1'b0}}, 1'b1} : window_reg;

    always_comb
    begin
        edge_next  = edge_reg;
        tick_next  = tick_reg;
        phase_next = phase_cur;
        prev_next  = prev_reg;
        cal_next   = cal_reg;
        edge_inc   = edge_reg;
        window_end = 1'b0;
        need_div   = 1'b0;
        if (recalibrate)
        begin
            edge_next  = '0;
            tick_next  = '0;
            phase_next = PHASE_RED;
            cal_next   = 1'b1;
            prev_next  = sensor_level;
        end
        else
        begin
            if (prev_reg && !sensor_level && (edge_reg != COUNT_MAX))
            begin
                edge_inc = edge_reg + 1'b1;
            end
            prev_next = sensor_level;
            tick_next = tick_reg + 1'b1;
            edge_next = edge_inc;
            if (tick_next >= win_eff)
            begin
                window_end = 1'b1;
                edge_next  = '0;
                tick_next  = '0;
                if (phase_cur == PHASE_BLUE)
                begin
                    phase_next = PHASE_RED;
                    if (cal_reg)
                    begin
                        cal_next = 1'b0;
                    end
                    else
                    begin
                        need_div = 1'b1;
                    end
                end
                else
                begin
                    phase_next = phase_cur + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        case (cw.cond)
            COND_NEXT:     cond_true = 1'b0;
            COND_NO_DIV:   cond_true = !(accept && need_div);
            COND_DIV_BUSY: cond_true = (cnt_reg != '0);
            COND_OUT_BUSY: cond_true = out_busy;
            default:       cond_true = 1'b0;
        endcase
        pc_next = cond_true ? cw.target : pc_reg + 1'b1;
    end

    assign numer  = {round_reg[cw.color], {VALUE_WIDTH{1'b0}}}
                  - {{VALUE_WIDTH{1'b0}}, round_reg[cw.color]};
    assign div_ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        sat_next = sat_reg;
        case (cw.op)
            OP_LOAD:
            begin
                rem_next = numer;
                dsh_next = {white_reg[cw.color], {VALUE_WIDTH{1'b0}}};
                cnt_next = DIV_TOP_BIT;
                quo_next = '0;
                sat_next = (white_reg[cw.color] == '0);
            end
            OP_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                    if (cnt_reg == DIV_TOP_BIT)
                    begin
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        quo_next[cnt_reg[2:0]] = 1'b1;
                    end
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign load_tick  = (cw.op == OP_TICK) && accept && !need_div;
    assign load_emit  = (cw.op == OP_EMIT) && !out_busy;
    assign show_phase = load_emit ? phase_reg : phase_next;
    assign show_cal   = load_emit ? cal_reg : cal_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            scale_reg     <= SCALE_RESET;
            edge_reg      <= '0;
            tick_reg      <= '0;
            phase_reg     <= PHASE_RED;
            prev_reg      <= 1'b1;
            cal_reg       <= 1'b1;
            round_reg     <= '{default: '0};
            white_reg     <= '{default: '0};
            pc_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_WINDOW_TICKS)
                begin
                    window_reg <= cfg_data;
                end
                else if (cfg_index == REG_FREQ_SCALE)
                begin
                    scale_reg <= cfg_data[SCALE_WIDTH-1:0];
                end
            end
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
            if (accept)
            begin
                edge_reg  <= edge_next;
                tick_reg  <= tick_next;
                phase_reg <= phase_next;
                prev_reg  <= prev_next;
                cal_reg   <= cal_next;
                if (recalibrate)
                begin
                    round_reg <= '{default: '0};
                end
                else if (window_end)
                begin
                    round_reg[phase_cur] <= edge_inc;
                    if ((phase_cur == PHASE_BLUE) && cal_reg)
                    begin
                        white_reg[0] <= round_reg[0];
                        white_reg[1] <= round_reg[1];
                        white_reg[2] <= edge_inc;
                    end
                end
            end
            if (load_tick || load_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
        if ((cw.op == OP_DIV) && (cnt_reg == '0))
        begin
            res_reg[cw.color] <= sat_next ? VALUE_MAX : quo_next;
        end
        if (load_tick || load_emit)
        begin
            s2_reg        <= (show_phase == PHASE_GREEN);
            s3_reg        <= (show_phase == PHASE_GREEN) || (show_phase == PHASE_BLUE);
            scale_out_reg <= scale_reg;
            cv_reg        <= load_emit;
            calib_reg     <= show_cal;
            red_reg       <= load_emit ? res_reg[0] : '0;
            green_reg     <= load_emit ? res_reg[1] : '0;
            blue_reg      <= load_emit ? res_reg[2] : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign filter_s2   = s2_reg;
    assign filter_s3   = s3_reg;
    assign scale_pins  = scale_out_reg;
    assign color_valid = cv_reg;
    assign red_value   = red_reg;
    assign green_value = green_reg;
    assign blue_value  = blue_reg;
    assign calibrating = calib_reg;

endmodule

`default_nettype wire

FILE: sv/csfb_checker.sv
// Port-level checker for the color sensor frequency balancer, bound to the top.
// Depends on csfb_pkg and color_sensor_frequency_balancer_top.
`default_nettype none

module csfb_checker
    import csfb_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic                   filter_s2,
    input wire logic                   filter_s3,
    input wire logic                   color_valid,
    input wire logic [VALUE_WIDTH-1:0] red_value,
    input wire logic [VALUE_WIDTH-1:0] green_value,
    input wire logic [VALUE_WIDTH-1:0] blue_value,
    input wire logic                   calibrating
);

    // A balanced triple is only given after calibration has finished.
    a_valid_not_calibrating: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && color_valid |-> !calibrating)
        else $error("color result during calibration");

    // A round ends with blue, so the filter is back on red with the triple.
    a_valid_on_red: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && color_valid |-> !filter_s2 && !filter_s3)
        else $error("color result not on red filter");

    // Without a triple all levels read zero.
    a_zero_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !color_valid |-> (red_value == '0) && (green_value == '0)
            && (blue_value == '0))
        else $error("levels not zero without a triple");

    // S2 is high only on the green filter, where S3 is high too.
    a_filter_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && filter_s2 |-> filter_s3)
        else $error("illegal filter select code");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_value)
            && $stable(color_valid))
        else $error("stalled result changed");

endmodule

bind color_sensor_frequency_balancer_top csfb_checker u_csfb_checker (.*);

`default_nettype wire
